>>> src/dls_pkg.sv
// Shared types, constants and the activation table builder for the dense layer.
// No dependencies; every other file but dls_ram refers to this package by scoped names.

package dls_pkg;

  // Default sizes handed to the top level parameters
  localparam int MAX_INPUTS_DEF  = 64;
  localparam int MAX_NEURONS_DEF = 32;

  // Activation table: entry i samples x = -8 + 16*i/TABLE_ENTRIES
  localparam int TABLE_ENTRIES = 256;
  localparam int TIDX_W        = $clog2(TABLE_ENTRIES);

  // Payload widths of the two channels
  localparam int FUNC_W   = 2;
  localparam int NIDX_W   = 5;
  localparam int IIDX_W   = 6;
  localparam int VALUE_W  = 16;
  localparam int ACT_W    = 16;
  localparam int FRAC_W   = 12;

  // Configuration register fields
  localparam int CFG_INPUTS_W  = 7;
  localparam int CFG_NEURONS_W = 6;
  localparam int APB_ADDR_W    = 3;
  localparam int APB_DATA_W    = 32;

  localparam logic REG_ACTIVE_INPUTS  = 1'b0;
  localparam logic REG_ACTIVE_NEURONS = 1'b1;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_WEIGHT = 2'd0,
    FUNC_BIAS   = 2'd1,
    FUNC_INPUT  = 2'd2
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BIAS,
    ST_MAC,
    ST_DRAIN_A,
    ST_DRAIN_B,
    ST_ROUND,
    ST_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept_en;
    logic bias_rd;
    logic mac_rd;
    logic round;
    logic emit;
    logic last;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic start;
    logic out_free;
  } status_t;

  localparam logic [63:0] Q31_ONE = 64'd1 << 31;

  // Elaboration-time builder for one table entry: e^-|x| by a truncated series
  // at |x|/256 squared eight times, then 1/(1+e^x) by shift-subtract division.
  function automatic logic [ACT_W-1:0] sig_entry(input int unsigned i);
    longint      scaled;
    logic        negx;
    logic [63:0] mag;
    logic [63:0] t;
    logic [63:0] u;
    logic [63:0] u2;
    logic [63:0] u3;
    logic [63:0] u4;
    logic [63:0] y;
    logic [63:0] num;
    logic [63:0] den;
    logic [63:0] rem;
    logic [63:0] quo;
    scaled = longint'(16 * i) - longint'(8 * TABLE_ENTRIES);
    negx   = scaled < 0;
    mag    = negx ? 64'(-scaled) : 64'(scaled);
    t      = (mag << 16) / TABLE_ENTRIES;
    u      = t << 7;
    u2     = (u * u) >> 31;
    u3     = (u2 * u) >> 31;
    u4     = (u3 * u) >> 31;
    y      = Q31_ONE + (u2 >> 1) + (u4 / 24) - u - (u3 / 6);
    for (int k = 0; k < 8; k++) begin
      y = (y * y + (64'd1 << 30)) >> 31;
    end
    num = negx ? Q31_ONE : y;
    den = Q31_ONE + y;
    rem = (num << 16) + (den >> 1);
    quo = 64'd0;
    for (int b = 17; b >= 0; b--) begin
      if (rem >= (den << b)) begin
        rem = rem - (den << b);
        quo = quo | (64'd1 << b);
      end
    end
    if (quo > 64'd65535) begin
      quo = 64'd65535;
    end
    return quo[ACT_W-1:0];
  endfunction

endpackage

>>> src/dls_if.sv
// Valid/ready channel interfaces for the dense layer: item input and result output.
// Depends on dls_pkg for the payload widths.

interface dls_in_if;
  logic                               valid;
  logic                               ready;
  logic [dls_pkg::FUNC_W-1:0]         func;
  logic [dls_pkg::NIDX_W-1:0]         neuron_index;
  logic [dls_pkg::IIDX_W-1:0]         input_index;
  logic signed [dls_pkg::VALUE_W-1:0] value;

  modport source (output valid, func, neuron_index, input_index, value, input ready);
  modport sink   (input valid, func, neuron_index, input_index, value, output ready);
endinterface

interface dls_out_if;
  logic                        valid;
  logic                        ready;
  logic [dls_pkg::NIDX_W-1:0]  neuron_out;
  logic [dls_pkg::ACT_W-1:0]   activation;
  logic                        last;

  modport source (output valid, neuron_out, activation, last, input ready);
  modport sink   (input valid, neuron_out, activation, last, output ready);
endinterface

>>> src/dense_layer_sigmoid_top.sv
// Top level of the dense layer with mirrored sigmoid: configuration registers,
// controller and datapath. Depends on dls_pkg, dls_if, dls_ctrl and dls_datapath.
//
// Usage:
//   items   : valid/ready channel. func 0 writes a weight at (neuron_index, input_index),
//             func 1 writes a neuron bias, func 2 stores an input element. A beat
//             with func 2 at column active_inputs-1 starts the layer evaluation.
//   results : valid/ready channel, one beat per active neuron in ascending order,
//             last set on the final neuron. activation is 1/(1+e^z) in Q0.16.
//   APB     : active_inputs at address 0, active_neurons at address 4; writes are
//             clamped to [1, MAX_INPUTS] and [1, MAX_NEURONS].
// Sequence: after the closing element each neuron passes through a bias read, one MAC
//   step per column, two pipeline drain steps, rounding and hand-over, paced by the
//   single multiplier walking the weight memory one word per cycle.
// items.ready is low from the closing element until the last result sits in the
//   output register. A stalled receiver holds the sequencer in its hand-over step.
// Reset restores 64 inputs and 32 neurons; the stores are not cleared and must be
//   written before use. The first result is held until results.ready.

module dense_layer_sigmoid_top #(
  parameter int MAX_INPUTS  = dls_pkg::MAX_INPUTS_DEF,
  parameter int MAX_NEURONS = dls_pkg::MAX_NEURONS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  dls_in_if.sink                            items,
  dls_out_if.source                         results,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [dls_pkg::APB_ADDR_W-1:0]    paddr,
  input  logic [dls_pkg::APB_DATA_W-1:0]    pwdata,
  output logic [dls_pkg::APB_DATA_W-1:0]    prdata,
  output logic                              pready
);

  localparam int AI_W = $clog2(MAX_INPUTS + 1);
  localparam int AN_W = $clog2(MAX_NEURONS + 1);
  localparam int J_W  = $clog2(MAX_INPUTS);
  localparam int N_W  = MAX_NEURONS > 1 ? $clog2(MAX_NEURONS) : 1;
  localparam int WA_W = $clog2(MAX_NEURONS * MAX_INPUTS) > 0 ?
                        $clog2(MAX_NEURONS * MAX_INPUTS) : 1;
  localparam int AI_RST = MAX_INPUTS < 64 ? MAX_INPUTS : 64;
  localparam int AN_RST = MAX_NEURONS < 32 ? MAX_NEURONS : 32;

  logic [AI_W-1:0] active_inputs;
  logic [AN_W-1:0] active_neurons;
  logic [AI_W-1:0] inputs_wr;
  logic [AN_W-1:0] neurons_wr;
  logic            cfg_we;
  logic            reg_sel;
  int unsigned     in_raw;
  int unsigned     nr_raw;

  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite && pready;
  assign reg_sel = paddr[2];
  assign in_raw  = 32'(pwdata[dls_pkg::CFG_INPUTS_W-1:0]);
  assign nr_raw  = 32'(pwdata[dls_pkg::CFG_NEURONS_W-1:0]);

  // Clamp written counts into the supported range
  always_comb begin
    if (in_raw == 0) begin
      inputs_wr = AI_W'(1);
    end else if (in_raw > 32'(MAX_INPUTS)) begin
      inputs_wr = AI_W'(MAX_INPUTS);
    end else begin
      inputs_wr = AI_W'(in_raw);
    end
    if (nr_raw == 0) begin
      neurons_wr = AN_W'(1);
    end else if (nr_raw > 32'(MAX_NEURONS)) begin
      neurons_wr = AN_W'(MAX_NEURONS);
    end else begin
      neurons_wr = AN_W'(nr_raw);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active_inputs  <= AI_W'(AI_RST);
      active_neurons <= AN_W'(AN_RST);
    end else if (cfg_we) begin
      case (reg_sel)
        dls_pkg::REG_ACTIVE_INPUTS:  active_inputs  <= inputs_wr;
        dls_pkg::REG_ACTIVE_NEURONS: active_neurons <= neurons_wr;
        default:                     active_inputs  <= active_inputs;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      dls_pkg::REG_ACTIVE_INPUTS:  prdata = dls_pkg::APB_DATA_W'(active_inputs);
      dls_pkg::REG_ACTIVE_NEURONS: prdata = dls_pkg::APB_DATA_W'(active_neurons);
      default:                     prdata = '0;
    endcase
  end

  dls_pkg::cmd_t    cmd;
  dls_pkg::status_t st;
  logic [N_W-1:0]   neuron;
  logic [J_W-1:0]   in_col;
  logic [WA_W-1:0]  w_addr;

  dls_ctrl #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_NEURONS (MAX_NEURONS)
  ) u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .st             (st),
    .active_inputs  (active_inputs),
    .active_neurons (active_neurons),
    .cmd            (cmd),
    .neuron         (neuron),
    .in_col         (in_col),
    .w_addr         (w_addr)
  );

  dls_datapath #(
    .MAX_INPUTS  (MAX_INPUTS),
    .MAX_NEURONS (MAX_NEURONS)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .items         (items),
    .results       (results),
    .cmd           (cmd),
    .st            (st),
    .active_inputs (active_inputs),
    .neuron        (neuron),
    .in_col        (in_col),
    .w_addr        (w_addr)
  );

  // Counts stay inside their clamped ranges
  a_inputs_range: assert property (@(posedge clk) disable iff (rst)
    active_inputs != '0 && active_inputs <= AI_W'(MAX_INPUTS))
    else $error("active_inputs out of range");

  a_neurons_range: assert property (@(posedge clk) disable iff (rst)
    active_neurons != '0 && active_neurons <= AN_W'(MAX_NEURONS))
    else $error("active_neurons out of range");

  // A closing element stops intake while the neurons are evaluated
  a_start_blocks: assert property (@(posedge clk) disable iff (rst)
    items.valid && items.ready && st.start |=> !items.ready)
    else $error("items accepted during evaluation");

  // Results are only loaded while intake is closed
  a_emit_busy: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> !items.ready)
    else $error("result loaded while idle");

endmodule

>>> src/dls_ram.sv
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.

module dls_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/dls_ctrl.sv
// Sequencer for the dense layer: walks neurons and input columns, steers the datapath.
// Depends on dls_pkg for the state, command and status types.

module dls_ctrl #(
  parameter int MAX_INPUTS  = dls_pkg::MAX_INPUTS_DEF,
  parameter int MAX_NEURONS = dls_pkg::MAX_NEURONS_DEF,
  localparam int AI_W = $clog2(MAX_INPUTS + 1),
  localparam int AN_W = $clog2(MAX_NEURONS + 1),
  localparam int J_W  = $clog2(MAX_INPUTS),
  localparam int N_W  = MAX_NEURONS > 1 ? $clog2(MAX_NEURONS) : 1,
  localparam int WA_W = $clog2(MAX_NEURONS * MAX_INPUTS) > 0 ?
                        $clog2(MAX_NEURONS * MAX_INPUTS) : 1
) (
  input  logic                  clk,
  input  logic                  rst,
  input  dls_pkg::status_t      st,
  input  logic [AI_W-1:0]       active_inputs,
  input  logic [AN_W-1:0]       active_neurons,
  output dls_pkg::cmd_t         cmd,
  output logic [N_W-1:0]        neuron,
  output logic [J_W-1:0]        in_col,
  output logic [WA_W-1:0]       w_addr
);

  dls_pkg::state_t state;
  dls_pkg::state_t state_next;
  logic [WA_W-1:0] w_base;
  logic            col_last;
  logic            neuron_last;

  assign col_last    = AI_W'(in_col) == active_inputs - AI_W'(1);
  assign neuron_last = AN_W'(neuron) == active_neurons - AN_W'(1);
  assign w_addr      = w_base + WA_W'(in_col);

  always_comb begin
    state_next = state;
    case (state)
      dls_pkg::ST_IDLE: begin
        if (st.start) begin
          state_next = dls_pkg::ST_BIAS;
        end
      end
      dls_pkg::ST_BIAS:    state_next = dls_pkg::ST_MAC;
      dls_pkg::ST_MAC: begin
        if (col_last) begin
          state_next = dls_pkg::ST_DRAIN_A;
        end
      end
      dls_pkg::ST_DRAIN_A: state_next = dls_pkg::ST_DRAIN_B;
      dls_pkg::ST_DRAIN_B: state_next = dls_pkg::ST_ROUND;
      dls_pkg::ST_ROUND:   state_next = dls_pkg::ST_EMIT;
      dls_pkg::ST_EMIT: begin
        if (st.out_free) begin
          state_next = neuron_last ? dls_pkg::ST_IDLE : dls_pkg::ST_BIAS;
        end
      end
      default:             state_next = dls_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    case (state)
      dls_pkg::ST_IDLE:  cmd.accept_en = 1'b1;
      dls_pkg::ST_BIAS:  cmd.bias_rd   = 1'b1;
      dls_pkg::ST_MAC:   cmd.mac_rd    = 1'b1;
      dls_pkg::ST_ROUND: cmd.round     = 1'b1;
      dls_pkg::ST_EMIT: begin
        cmd.emit = st.out_free;
        cmd.last = neuron_last;
      end
      default:           cmd = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dls_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      neuron <= '0;
      in_col <= '0;
      w_base <= '0;
    end else begin
      case (state)
        dls_pkg::ST_IDLE: begin
          neuron <= '0;
          in_col <= '0;
          w_base <= '0;
        end
        dls_pkg::ST_BIAS: in_col <= '0;
        dls_pkg::ST_MAC:  in_col <= in_col + J_W'(1);
        dls_pkg::ST_EMIT: begin
          // advance to the next weight row once this result is handed over
          if (st.out_free) begin
            neuron <= neuron + N_W'(1);
            w_base <= w_base + WA_W'(MAX_INPUTS);
          end
        end
        default: begin
          neuron <= neuron;
        end
      endcase
    end
  end

endmodule

>>> src/dls_datapath.sv
// Datapath of the dense layer: weight, bias and input stores, one MAC, rounding,
// saturation, activation table and the output register. Depends on dls_pkg,
// dls_if and dls_ram.

module dls_datapath #(
  parameter int MAX_INPUTS  = dls_pkg::MAX_INPUTS_DEF,
  parameter int MAX_NEURONS = dls_pkg::MAX_NEURONS_DEF,
  localparam int AI_W  = $clog2(MAX_INPUTS + 1),
  localparam int J_W   = $clog2(MAX_INPUTS),
  localparam int N_W   = MAX_NEURONS > 1 ? $clog2(MAX_NEURONS) : 1,
  localparam int WA_W  = $clog2(MAX_NEURONS * MAX_INPUTS) > 0 ?
                         $clog2(MAX_NEURONS * MAX_INPUTS) : 1
) (
  input  logic               clk,
  input  logic               rst,
  dls_in_if.sink             items,
  dls_out_if.source          results,
  input  dls_pkg::cmd_t      cmd,
  output dls_pkg::status_t   st,
  input  logic [AI_W-1:0]    active_inputs,
  input  logic [N_W-1:0]     neuron,
  input  logic [J_W-1:0]     in_col,
  input  logic [WA_W-1:0]    w_addr
);

  localparam int VW    = dls_pkg::VALUE_W;
  localparam int PW    = 2 * VW;
  localparam int ACC_W = PW + 1 + $clog2(MAX_INPUTS);
  localparam int Q_W   = ACC_W + 1 - dls_pkg::FRAC_W;
  localparam int CW    = AI_W > dls_pkg::IIDX_W ? AI_W : dls_pkg::IIDX_W;
  localparam int IX_W  = VW + dls_pkg::TIDX_W + 1;
  localparam logic signed [Q_W-1:0] Z_MAX = Q_W'(32767);
  localparam logic signed [Q_W-1:0] Z_MIN = Q_W'(-32768);

  // Item decode and store writes
  logic            accept;
  logic            ni_ok;
  logic            ii_ok;
  logic            w_we;
  logic            b_we;
  logic            x_we;
  logic [WA_W-1:0] w_waddr;

  assign items.ready = cmd.accept_en;
  assign accept      = items.valid && items.ready;
  assign ni_ok       = int'(items.neuron_index) < MAX_NEURONS;
  assign ii_ok       = int'(items.input_index) < MAX_INPUTS;
  assign w_we        = accept && items.func == dls_pkg::FUNC_WEIGHT && ni_ok && ii_ok;
  assign b_we        = accept && items.func == dls_pkg::FUNC_BIAS && ni_ok;
  assign x_we        = accept && items.func == dls_pkg::FUNC_INPUT && ii_ok;
  assign w_waddr     = WA_W'(int'(items.neuron_index) * MAX_INPUTS + int'(items.input_index));

  // The element at the last active column closes the vector
  assign st.start = items.valid && items.func == dls_pkg::FUNC_INPUT && ii_ok &&
                    (CW'(items.input_index) == CW'(active_inputs) - CW'(1));

  logic [VW-1:0] w_q;
  logic [VW-1:0] b_q;
  logic [VW-1:0] x_q;

  dls_ram #(.WIDTH(VW), .DEPTH(MAX_NEURONS * MAX_INPUTS)) u_weights (
    .clk   (clk),
    .we    (w_we),
    .waddr (w_waddr),
    .wdata (items.value),
    .re    (cmd.mac_rd),
    .raddr (w_addr),
    .rdata (w_q)
  );

  dls_ram #(.WIDTH(VW), .DEPTH(MAX_NEURONS)) u_bias (
    .clk   (clk),
    .we    (b_we),
    .waddr (N_W'(items.neuron_index)),
    .wdata (items.value),
    .re    (cmd.bias_rd),
    .raddr (neuron),
    .rdata (b_q)
  );

  dls_ram #(.WIDTH(VW), .DEPTH(MAX_INPUTS)) u_inputs (
    .clk   (clk),
    .we    (x_we),
    .waddr (J_W'(items.input_index)),
    .wdata (items.value),
    .re    (cmd.mac_rd),
    .raddr (in_col),
    .rdata (x_q)
  );

  // MAC pipeline: read, multiply, accumulate
  logic                    bias_v1;
  logic                    mac_v1;
  logic                    mac_v2;
  logic signed [PW-1:0]    prod;
  logic signed [ACC_W-1:0] acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      bias_v1 <= 1'b0;
      mac_v1  <= 1'b0;
      mac_v2  <= 1'b0;
    end else begin
      bias_v1 <= cmd.bias_rd;
      mac_v1  <= cmd.mac_rd;
      mac_v2  <= mac_v1;
    end
  end

  always_ff @(posedge clk) begin
    if (mac_v1) begin
      prod <= $signed(w_q) * $signed(x_q);
    end
    if (bias_v1) begin
      acc <= ACC_W'($signed(b_q)) <<< dls_pkg::FRAC_W;
    end else if (mac_v2) begin
      acc <= acc + ACC_W'(prod);
    end
  end

  // Round half up to Q4.12 and clamp to [-8, 8)
  logic signed [ACC_W:0]   rnd;
  logic signed [Q_W-1:0]   q;
  logic signed [VW-1:0]    z_next;
  logic signed [VW-1:0]    z;

  assign rnd = (ACC_W + 1)'(acc) + (ACC_W + 1)'(2048);
  assign q   = rnd[ACC_W:dls_pkg::FRAC_W];

  always_comb begin
    if (q > Z_MAX) begin
      z_next = 16'sh7FFF;
    end else if (q < Z_MIN) begin
      z_next = 16'sh8000;
    end else begin
      z_next = q[VW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.round) begin
      z <= z_next;
    end
  end

  // Activation table, built at elaboration
  logic [dls_pkg::ACT_W-1:0] lut [dls_pkg::TABLE_ENTRIES];

  for (genvar g = 0; g < dls_pkg::TABLE_ENTRIES; g++) begin : g_lut
    localparam logic [dls_pkg::ACT_W-1:0] ENTRY = dls_pkg::sig_entry(g);
    assign lut[g] = ENTRY;
  end

  logic [VW-1:0]               z_off;
  logic [IX_W-1:0]             idx_full;
  logic [dls_pkg::TIDX_W-1:0]  idx;

  assign z_off    = {~z[VW-1], z[VW-2:0]};
  assign idx_full = IX_W'(z_off) * IX_W'(dls_pkg::TABLE_ENTRIES);
  assign idx      = idx_full[VW +: dls_pkg::TIDX_W];

  // Output register: load on emit, drop once the beat is taken
  assign st.out_free = !results.valid || results.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (cmd.emit) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      results.neuron_out <= dls_pkg::NIDX_W'(neuron);
      results.activation <= lut[idx];
      results.last       <= cmd.last;
    end
  end

endmodule
